// File: src/cdt_pkg.sv
// ----------------------------------------------------------------------------
// cdt_pkg
// Shared types and constants for the configuration directive tokenizer:
// result kinds, field widths, the result record and the special characters.
// ----------------------------------------------------------------------------
package cdt_pkg;

  // Field widths of a result transaction
  localparam int unsigned KIND_W = 3;
  localparam int unsigned TOK_W  = 32;

  // Default parameter values
  localparam int unsigned OFFSET_BITS_DEF = 32;
  localparam int unsigned NEST_BITS_DEF   = 8;

  // Result kinds
  localparam logic [KIND_W-1:0] K_NAME       = 3'd0;
  localparam logic [KIND_W-1:0] K_ARG        = 3'd1;
  localparam logic [KIND_W-1:0] K_END        = 3'd2;
  localparam logic [KIND_W-1:0] K_INCOMPLETE = 3'd3;
  localparam logic [KIND_W-1:0] K_OVERFLOW   = 3'd4;

  // Special characters
  localparam logic [7:0] CH_LBRACE  = 8'h7B;
  localparam logic [7:0] CH_RBRACE  = 8'h7D;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;

  // One result record
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TOK_W-1:0]  offset;
    logic [TOK_W-1:0]  length;
    logic              done;
  } cdt_result_t;

endpackage

// File: src/config_directive_tokenizer.sv
// ----------------------------------------------------------------------------
// config_directive_tokenizer
// Tokenizes configuration directives, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one text byte per
//   transaction, with final_byte_i marking the last byte of a buffer.
//   Output channel (out_valid_o / out_ready_i) carries one token report per
//   transaction: kind, start offset, length and a directive-complete flag.
//   A byte gives zero, one or two reports.
//   An accepted byte is held in the input register until the parse step fires
//   and writes its reports into the four-entry result queue. Its first report
//   is offered from the queue in the cycle after the parse step and can be
//   taken at an edge where out_ready_i is high.
//   Throughput: one byte per cycle. The parse step fires whenever the queue
//   has two free entries, so with out_ready_i high the block never stalls.
//   When the receiver stalls the queue fills and the input register holds;
//   in_ready_o drops once the input register is full and cannot move on.
//   Reset clears the parser state, the byte position, the input register
//   and the queue. After a transaction with final_byte_i set the parser
//   state and byte position return to their reset values.
// ----------------------------------------------------------------------------
module config_directive_tokenizer #(
  parameter int unsigned OFFSET_BITS = cdt_pkg::OFFSET_BITS_DEF,
  parameter int unsigned NEST_BITS   = cdt_pkg::NEST_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       final_byte_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [cdt_pkg::KIND_W-1:0] event_kind_o,
  output logic [cdt_pkg::TOK_W-1:0]  token_offset_o,
  output logic [cdt_pkg::TOK_W-1:0]  token_length_o,
  output logic                       directive_done_o
);
  import cdt_pkg::*;

  // Parse modes
  localparam logic [2:0] M_IDLE    = 3'd0;
  localparam logic [2:0] M_NAME    = 3'd1;
  localparam logic [2:0] M_GAP     = 3'd2;
  localparam logic [2:0] M_ARG     = 3'd3;
  localparam logic [2:0] M_BRACE   = 3'd4;
  localparam logic [2:0] M_COMMENT = 3'd5;

  localparam logic [1:0] R_IDLE = 2'd0;

  // Result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);
  localparam logic [CntW-1:0] SpaceLimit = CntW'(FifoDepth - 2);

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NEWLINE) || (c == CH_TAB) || (c == CH_CR);
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  // Input register
  logic       in_valid_q;
  logic [7:0] text_q;
  logic       final_q;

  // Parser state
  logic [2:0]             mode_q, mode_d;
  logic [1:0]             ret_q, ret_d;
  logic                   esc_q, esc_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [OFFSET_BITS-1:0] begin_q, begin_d;
  logic [NEST_BITS-1:0]   depth_q, depth_d;

  // Result queue
  cdt_result_t         fifo_q [FifoDepth];
  logic [PtrW-1:0]     head_q, tail_q;
  logic [CntW-1:0]     count_q, count_d;

  logic                fire;
  logic                pop;
  logic                tok_v, inc_v;
  cdt_result_t         tok_r, inc_r;

  // Parse step fires when the queue can take two reports
  assign fire       = in_valid_q && (count_q <= SpaceLimit);
  assign in_ready_o = !in_valid_q || fire;

  // Hold or load the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      text_q  <= text_byte_i;
      final_q <= final_byte_i;
    end
  end

  // Parse one byte
  always_comb begin
    logic [7:0]             c;
    logic                   do_handle;
    logic                   literal;
    logic [OFFSET_BITS-1:0] len;
    logic [KIND_W-1:0]      tkind;
    logic                   open_dir;

    c         = text_q;
    do_handle = 1'b0;
    literal   = 1'b1;
    len       = pos_q - begin_q;
    tkind     = (mode_q == M_NAME) ? K_NAME : K_ARG;
    open_dir  = 1'b0;

    mode_d  = mode_q;
    ret_d   = ret_q;
    esc_d   = esc_q;
    begin_d = begin_q;
    depth_d = depth_q;
    pos_d   = pos_q + OFFSET_BITS'(1);

    tok_v        = 1'b0;
    tok_r.kind   = K_ARG;
    tok_r.offset = TOK_W'(begin_q);
    tok_r.length = TOK_W'(len);
    tok_r.done   = 1'b0;

    inc_v        = 1'b0;
    inc_r.kind   = K_INCOMPLETE;
    inc_r.offset = TOK_W'(pos_q);
    inc_r.length = '0;
    inc_r.done   = 1'b0;

    if (mode_q == M_COMMENT) begin
      // Drop comment bytes up to the newline
      if (c == CH_NEWLINE) begin
        mode_d = {1'b0, ret_q};
      end
    end else if (mode_q == M_BRACE) begin
      // Track inner braces; the closing brace ends the directive
      if (c == CH_RBRACE) begin
        if (depth_q == '0) begin
          tok_v      = 1'b1;
          tok_r.kind = K_ARG;
          tok_r.done = 1'b1;
          mode_d     = M_IDLE;
        end else begin
          depth_d = depth_q - NEST_BITS'(1);
        end
      end else if (c == CH_LBRACE) begin
        if (depth_q == '1) begin
          tok_v        = 1'b1;
          tok_r.kind   = K_OVERFLOW;
          tok_r.offset = TOK_W'(pos_q);
          tok_r.length = '0;
          mode_d       = M_IDLE;
          depth_d      = '0;
        end else begin
          depth_d = depth_q + NEST_BITS'(1);
        end
      end
    end else if (esc_q) begin
      // Swallow whitespace after a backslash
      if (!is_space(c)) begin
        esc_d     = 1'b0;
        do_handle = 1'b1;
        literal   = (c != CH_SEMI);
      end
    end else if (c == CH_BSLASH) begin
      esc_d = 1'b1;
    end else begin
      do_handle = 1'b1;
    end

    if (do_handle) begin
      case (mode_q)
        M_IDLE: begin
          if (is_letter(c)) begin
            begin_d = pos_q;
            mode_d  = M_NAME;
          end else if (c == CH_HASH) begin
            ret_d  = R_IDLE;
            mode_d = M_COMMENT;
          end
        end
        M_NAME, M_ARG: begin
          tok_r.kind = tkind;
          if (c == CH_HASH) begin
            ret_d  = mode_q[1:0];
            mode_d = M_COMMENT;
          end else if (is_space(c) && literal) begin
            tok_v  = 1'b1;
            mode_d = M_GAP;
          end else if (c == CH_LBRACE) begin
            tok_v   = 1'b1;
            mode_d  = M_BRACE;
            depth_d = '0;
            begin_d = pos_q + OFFSET_BITS'(1);
          end else if ((c == CH_SEMI) && literal) begin
            tok_v      = 1'b1;
            tok_r.done = 1'b1;
            mode_d     = M_IDLE;
          end
        end
        M_GAP: begin
          if (c == CH_HASH) begin
            ret_d  = M_GAP[1:0];
            mode_d = M_COMMENT;
          end else if ((is_space(c) || (c == CH_BSLASH)) && literal) begin
            mode_d = M_GAP;
          end else if ((c == CH_SEMI) && literal) begin
            tok_v        = 1'b1;
            tok_r.kind   = K_END;
            tok_r.offset = TOK_W'(pos_q);
            tok_r.length = '0;
            tok_r.done   = 1'b1;
            mode_d       = M_IDLE;
          end else if (c == CH_LBRACE) begin
            mode_d  = M_BRACE;
            depth_d = '0;
            begin_d = pos_q + OFFSET_BITS'(1);
          end else begin
            begin_d = pos_q;
            mode_d  = M_ARG;
          end
        end
        default: begin
          mode_d = M_IDLE;
        end
      endcase
    end

    // Close the buffer: report an open directive, then clear all state
    if (final_q) begin
      open_dir = ((mode_d >= M_NAME) && (mode_d <= M_BRACE)) ||
                 ((mode_d == M_COMMENT) && (ret_d != R_IDLE));
      inc_v   = open_dir;
      mode_d  = M_IDLE;
      ret_d   = R_IDLE;
      esc_d   = 1'b0;
      pos_d   = '0;
      begin_d = '0;
      depth_d = '0;
    end
  end

  // Advance parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= M_IDLE;
      ret_q   <= R_IDLE;
      esc_q   <= 1'b0;
      pos_q   <= '0;
      begin_q <= '0;
      depth_q <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      ret_q   <= ret_d;
      esc_q   <= esc_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
      depth_q <= depth_d;
    end
  end

  // Result queue: push up to two reports, pop one
  logic [1:0]  push_n;
  cdt_result_t first_r;

  assign pop     = out_valid_o && out_ready_i;
  assign push_n  = fire ? ({1'b0, tok_v} + {1'b0, inc_v}) : 2'd0;
  assign first_r = tok_v ? tok_r : inc_r;
  assign count_d = count_q + CntW'(push_n) - CntW'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_q + PtrW'(pop);
      tail_q  <= tail_q + PtrW'(push_n);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[tail_q] <= first_r;
    end
    if (push_n == 2'd2) begin
      fifo_q[tail_q + PtrW'(1)] <= inc_r;
    end
  end

  // Drive the output channel from the queue head
  assign out_valid_o      = (count_q != '0);
  assign event_kind_o     = fifo_q[head_q].kind;
  assign token_offset_o   = fifo_q[head_q].offset;
  assign token_length_o   = fifo_q[head_q].length;
  assign directive_done_o = fifo_q[head_q].done;

endmodule

// File: src/cdt_checker.sv
// ----------------------------------------------------------------------------
// cdt_checker
// Port-level checks on the tokenizer's result channel, bound to the top.
// ----------------------------------------------------------------------------
module cdt_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_o,
  input logic                       out_ready_i,
  input logic [cdt_pkg::KIND_W-1:0] event_kind_o,
  input logic [cdt_pkg::TOK_W-1:0]  token_offset_o,
  input logic [cdt_pkg::TOK_W-1:0]  token_length_o,
  input logic                       directive_done_o
);
  import cdt_pkg::*;

  // No transaction is offered in the cycle after a reset edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered during reset");

  // A stalled transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(event_kind_o) &&
      $stable(token_offset_o) && $stable(token_length_o) && $stable(directive_done_o))
    else $error("stalled result changed");

  // Only the defined kinds are reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> event_kind_o <= K_OVERFLOW)
    else $error("undefined result kind");

  // Positional kinds carry no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == K_END || event_kind_o == K_INCOMPLETE ||
      event_kind_o == K_OVERFLOW) |-> token_length_o == '0)
    else $error("non-zero length on positional result");

  // Incomplete and overflow reports never close a directive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_kind_o == K_INCOMPLETE || event_kind_o == K_OVERFLOW)
      |-> !directive_done_o)
    else $error("directive closed by wrong kind");

endmodule

bind config_directive_tokenizer cdt_checker u_cdt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .out_valid_o      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .event_kind_o     (event_kind_o),
  .token_offset_o   (token_offset_o),
  .token_length_o   (token_length_o),
  .directive_done_o (directive_done_o)
);
